[src/mahd_pkg.sv]
// Package for the moving-average hysteresis detector.
// Holds the window size, derived widths, the reciprocal used for the mean,
// and the configuration register indexes. Depends on nothing.
package mahd_pkg;

  // Number of samples averaged (1 to 64).
  localparam int WINDOW = 5;

  // Sample and threshold width.
  localparam int SAMPLE_W = 16;

  // Bits needed to index the ring; at least one bit.
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // The running sum of WINDOW samples stays below 2**SUM_W.
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  // Division by WINDOW as a multiply by a rounded-up reciprocal. With
  // SHIFT = SUM_W + ceil(log2(WINDOW)) the quotient is exact for every
  // sum below 2**SUM_W, and the reciprocal fits in SUM_W + 1 bits.
  localparam int  DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int  RECIP_W   = SUM_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int  PROD_W    = SUM_W + RECIP_W;

  // Configuration port.
  localparam int CFG_IDX_W = 4;

  // Reset values of the thresholds.
  localparam logic [SAMPLE_W-1:0] OPEN_THR_RST  = SAMPLE_W'(800);
  localparam logic [SAMPLE_W-1:0] CLOSE_THR_RST = SAMPLE_W'(100);

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_OPEN_THR  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_CLOSE_THR = cfg_idx_t'(1);

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam slot_t LAST_SLOT = SLOT_W'(WINDOW - 1);

endpackage

[src/moving_average_hysteresis_detector.sv]
// Moving-average detector with a hysteresis comparator, top level.
// Uses mahd_pkg for widths, the reciprocal constant and register indexes.
// A result passes through the sum stage register and then the output register.
// Throughput: one sample per cycle; the sum and output registers hold one item
// each, and the input stalls only while both are full and the result stalls.
// Reset (rst_n low, synchronous): ring, sum, slot and state cleared,
// thresholds back to 800 (open) and 100 (close), no result pending.
module moving_average_hysteresis_detector (
  input  logic                clk,
  input  logic                rst_n,
  // Sample channel
  input  logic                in_valid,
  output logic                in_stall,
  input  mahd_pkg::sample_t   in_sample,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output mahd_pkg::sample_t   out_average,
  output logic                out_is_open,
  output logic                out_opened_pulse,
  output logic                out_closed_pulse,
  output logic                out_cycle_complete,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mahd_pkg::cfg_idx_t  cfg_index,
  input  mahd_pkg::sample_t   cfg_data
);
  import mahd_pkg::*;

  // Configuration registers
  sample_t open_thr_r;
  sample_t close_thr_r;

  // Window state
  sample_t ring_r [WINDOW];
  slot_t   slot_r;
  slot_t   slot_nxt;
  sum_t    sum_r;
  sum_t    sum_nxt;

  // Sum stage holding register
  logic    s1_valid_r;
  sum_t    s1_sum_r;

  // Comparator state
  logic    open_r;
  logic    pending_r;
  logic    open_nxt;
  logic    pending_nxt;
  logic    opened;
  logic    closed;
  logic    cycle;

  // Mean
  logic [PROD_W-1:0] prod;
  sample_t           avg;

  // Output register
  logic    out_valid_r;
  sample_t out_avg_r;
  logic    out_open_r;
  logic    out_opened_r;
  logic    out_closed_r;
  logic    out_cycle_r;

  // Handshake
  logic    out_free;
  logic    in_take;
  logic    s1_move;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r  <= OPEN_THR_RST;
      close_thr_r <= CLOSE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OPEN_THR:  open_thr_r  <= cfg_data;
        REG_CLOSE_THR: close_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running sum: drop the oldest sample, add the new one.
  always_comb begin
    sum_nxt  = sum_r - sum_t'(ring_r[slot_r]) + sum_t'(in_sample);
    slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + slot_t'(1);
  end

  // Ring, slot pointer and sum stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
      slot_r     <= '0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        ring_r[slot_r] <= in_sample;
        slot_r         <= slot_nxt;
        sum_r          <= sum_nxt;
        s1_valid_r     <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sum_r <= sum_nxt;
    end
  end

  // Mean by reciprocal multiply, then the hysteresis decision.
  always_comb begin
    prod        = PROD_W'(s1_sum_r) * PROD_W'(RECIP);
    avg         = SAMPLE_W'(prod >> DIV_SHIFT);
    opened      = 1'b0;
    closed      = 1'b0;
    open_nxt    = open_r;
    pending_nxt = pending_r;
    if (!open_r) begin
      if (avg > open_thr_r) begin
        opened      = 1'b1;
        open_nxt    = 1'b1;
        pending_nxt = 1'b1;
      end
    end else if (avg < close_thr_r) begin
      closed   = 1'b1;
      open_nxt = 1'b0;
    end
    cycle = pending_nxt && !open_nxt;
    if (cycle) begin
      pending_nxt = 1'b0;
    end
  end

  // Comparator state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        open_r      <= open_nxt;
        pending_r   <= pending_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_avg_r    <= avg;
      out_open_r   <= open_nxt;
      out_opened_r <= opened;
      out_closed_r <= closed;
      out_cycle_r  <= cycle;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average        = out_avg_r;
  assign out_is_open        = out_open_r;
  assign out_opened_pulse   = out_opened_r;
  assign out_closed_pulse   = out_closed_r;
  assign out_cycle_complete = out_cycle_r;

endmodule

[src/mahd_checker.sv]
// Port-level checks for the moving-average hysteresis detector.
// Uses mahd_pkg for port types; bound to the top level below.
module mahd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mahd_pkg::sample_t   out_average,
  input logic                out_is_open,
  input logic                out_opened_pulse,
  input logic                out_closed_pulse,
  input logic                out_cycle_complete
);

  // A stalled result stays on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("result dropped or changed while stalled");

  // The input only backs up when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // An opening item reports the open state, a closing one the closed state.
  a_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_opened_pulse && !out_is_open) &&
                  !(out_closed_pulse && out_is_open))
    else $error("event pulse disagrees with state");

  // Every close ends an earlier open, so it always completes a cycle.
  a_cycle_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cycle_complete == out_closed_pulse)
    else $error("cycle flag does not match close event");

endmodule

bind moving_average_hysteresis_detector mahd_checker u_mahd_checker (.*);

[sim/moving_average_hysteresis_detector_test.sv]
// Self-checking testbench for the moving-average hysteresis detector.
// Predicts every result in step with accepted samples and checks each result
// as it leaves the block. Depends on mahd_pkg and the detector top level.
module moving_average_hysteresis_detector_test;
  import mahd_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int PRESSURE_ITEMS = 40;

  localparam sample_t  SAMPLE_MAX      = '1;
  localparam cfg_idx_t REG_SPARE_FIRST = REG_CLOSE_THR + cfg_idx_t'(1);
  localparam cfg_idx_t REG_SPARE_LAST  = '1;

  // One result of the detector, in port order.
  typedef struct packed {
    sample_t average;
    logic    is_open;
    logic    opened_pulse;
    logic    closed_pulse;
    logic    cycle_complete;
  } detection_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sample_t  in_sample;
  logic     out_valid;
  logic     out_stall;
  sample_t  out_average;
  logic     out_is_open;
  logic     out_opened_pulse;
  logic     out_closed_pulse;
  logic     out_cycle_complete;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  sample_t  cfg_data;

  moving_average_hysteresis_detector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_average        (out_average),
    .out_is_open        (out_is_open),
    .out_opened_pulse   (out_opened_pulse),
    .out_closed_pulse   (out_closed_pulse),
    .out_cycle_complete (out_cycle_complete),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Detector model: sample window, sum, hysteresis state and thresholds.
  sample_t     window_samples [WINDOW];
  int unsigned next_slot;
  sum_t        window_sum;
  bit          model_open;
  bit          model_pending;
  sample_t     open_thr;
  sample_t     close_thr;

  detection_t  pending_detections [$];
  detection_t  want;
  detection_t  got;

  int items_sent;
  int results_seen;
  int mismatch_count;
  int cycle_count;
  int tx_odds;
  int rx_odds;
  bit hold_request;
  int hold_left;
  int rx_burst_left;

  function automatic void reset_model();
    for (int i = 0; i < WINDOW; i++) begin
      window_samples[i] = '0;
    end
    next_slot     = 0;
    window_sum    = '0;
    model_open    = 1'b0;
    model_pending = 1'b0;
    open_thr      = OPEN_THR_RST;
    close_thr     = CLOSE_THR_RST;
  endfunction

  // Advance the window by one sample and apply the comparison that belongs
  // to the current state; returns the result the block should show.
  function automatic detection_t compute_detection(input sample_t s);
    detection_t d;
    sum_t       mean;
    d = '0;
    window_sum = window_sum - sum_t'(window_samples[next_slot]) + sum_t'(s);
    window_samples[next_slot] = s;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    mean = sum_t'(window_sum / WINDOW);
    if (!model_open) begin
      if (mean > open_thr) begin
        model_open      = 1'b1;
        model_pending   = 1'b1;
        d.opened_pulse  = 1'b1;
      end
    end else if (mean < close_thr) begin
      model_open     = 1'b0;
      d.closed_pulse = 1'b1;
    end
    if (model_pending && !model_open) begin
      model_pending    = 1'b0;
      d.cycle_complete = 1'b1;
    end
    d.average = sample_t'(mean);
    d.is_open = model_open;
    return d;
  endfunction

  // Watch all three channels: check results, track register writes and
  // predict each accepted sample.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_average, out_is_open, out_opened_pulse, out_closed_pulse,
               out_cycle_complete};
        results_seen++;
        if (pending_detections.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("MISMATCH result %0d: nothing expected, got avg=%0d open=%0b",
                     results_seen, got.average, got.is_open);
          end
          mismatch_count++;
        end else begin
          want = pending_detections.pop_front();
          if (got.average !== want.average || got.is_open !== want.is_open ||
              got.opened_pulse !== want.opened_pulse ||
              got.closed_pulse !== want.closed_pulse ||
              got.cycle_complete !== want.cycle_complete) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("MISMATCH result %0d: expected avg=%0d open=%0b up=%0b down=%0b cyc=%0b",
                       results_seen, want.average, want.is_open, want.opened_pulse,
                       want.closed_pulse, want.cycle_complete);
              $display("  got avg=%0d open=%0b up=%0b down=%0b cyc=%0b",
                       got.average, got.is_open, got.opened_pulse,
                       got.closed_pulse, got.cycle_complete);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OPEN_THR:  open_thr  = cfg_data;
          REG_CLOSE_THR: close_thr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_detections.push_back(compute_detection(in_sample));
      end
    end
  end

  // Result-side stall: a requested long hold first, then random bursts.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      out_stall <= 1'b1;
    end else if (rx_odds != 0 && $urandom_range(0, 99) < rx_odds) begin
      rx_burst_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one sample, after an optional idle burst, and wait until taken.
  task automatic send_sample(input sample_t s);
    int gap;
    if (tx_odds != 0 && $urandom_range(0, 99) < tx_odds) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering samples and let every result drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input sample_t value,
                                input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!keep_valid) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Program both thresholds while idle, optionally with a write to an
  // unused index in between that must change nothing.
  task automatic set_thresholds(input sample_t open_level, input sample_t close_level,
                                input bit with_spare);
    wait_idle();
    write_register(REG_OPEN_THR, open_level, 1'b1);
    if (with_spare) begin
      write_register(cfg_idx_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                     sample_t'($urandom), 1'b1);
    end
    write_register(REG_CLOSE_THR, close_level, 1'b0);
  endtask

  // Reset thresholds with the ring still holding zeros: 4000 alone averages
  // to exactly 800 and must not open; a further 5 lifts the mean to 801 and does.
  task automatic test_startup_fill();
    send_sample(sample_t'(4000));
    send_sample(sample_t'(5));
    repeat (4) send_sample('0);
  endtask

  // Full-scale samples ramp the mean up to the top, zeros bring it back.
  task automatic test_full_scale();
    repeat (WINDOW) send_sample(SAMPLE_MAX);
    repeat (WINDOW) send_sample('0);
  endtask

  // Thresholds at both ends, including fully overlapping ones where the
  // state flips on every sample.
  task automatic test_threshold_extremes();
    set_thresholds(SAMPLE_MAX, '0, 1'b1);
    repeat (3) send_sample(SAMPLE_MAX);
    set_thresholds('0, SAMPLE_MAX, 1'b1);
    repeat (4) send_sample('0);
  endtask

  // Hold the result side off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    set_thresholds(OPEN_THR_RST, CLOSE_THR_RST, 1'b0);
    tx_odds = 0;
    rx_odds = 0;
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS) send_sample(sample_t'($urandom));
  endtask

  // Runs of levels around the thresholds that drive full open-close cycles,
  // mixed with full-range noise and full-scale extremes.
  task automatic run_mixed_stream(input int count);
    int run_left;
    int kind;
    int level;
    int value;
    run_left = 0;
    kind     = 0;
    level    = 0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(3, 12);
        kind     = $urandom_range(0, 9);
        case (kind)
          3, 4:    level = int'(open_thr) + int'($urandom_range(1, 400));
          5, 6:    level = int'(close_thr) - int'($urandom_range(1, 400));
          7:       level = int'($urandom_range(open_thr, close_thr));
          8, 9:    level = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
          default: level = 0;
        endcase
      end
      run_left--;
      if (kind < 3) begin
        send_sample(sample_t'($urandom));
      end else begin
        value = level + int'($urandom_range(0, 6)) - 3;
        if (value < 0) begin
          value = 0;
        end else if (value > int'(SAMPLE_MAX)) begin
          value = int'(SAMPLE_MAX);
        end
        send_sample(sample_t'(value));
      end
    end
  endtask

  // Random phases, each with its own thresholds and idling; the last phase
  // runs at full rate on both sides.
  task automatic test_random_phases();
    sample_t o;
    sample_t c;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin
          c = sample_t'($urandom_range(0, 20000));
          o = c + sample_t'($urandom_range(0, 40000));
        end
        1: begin
          o = '0;
          c = (phase < 4) ? SAMPLE_MAX : sample_t'(1);
        end
        2: begin
          o = sample_t'($urandom);
          c = sample_t'($urandom);
        end
        default: begin
          o = OPEN_THR_RST;
          c = CLOSE_THR_RST;
        end
      endcase
      set_thresholds(o, c, 1'($urandom_range(0, 1)));
      if (phase == RANDOM_PHASES - 1) begin
        tx_odds = 0;
        rx_odds = 0;
      end else begin
        tx_odds = $urandom_range(0, 3) * 15;
        rx_odds = $urandom_range(0, 3) * 15;
      end
      run_mixed_stream(PHASE_ITEMS);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample     = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    items_sent    = 0;
    results_seen  = 0;
    mismatch_count = 0;
    cycle_count   = 0;
    tx_odds       = 0;
    rx_odds       = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    rx_burst_left = 0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_startup_fill();
    test_full_scale();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();

    // Drain and give the pipeline time to show anything stray.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_detections.size() != 0) begin
      mismatch_count += pending_detections.size();
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
